@@ rtl/core/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and codes of the preemptive priority scheduler: action codes,
// field widths and the slot record kept in the slot memory.
// ----------------------------------------------------------------------------
package pps_pkg;

	localparam int ACTION_W = 2;
	localparam int SLOT_W   = 4;
	localparam int IDENT_W  = 16;
	localparam int PRIO_W   = 8;
	localparam int TIME_W   = 16;
	localparam int CLOCK_W  = 32;

	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

	localparam logic [CLOCK_W-1:0] CLOCK_MAX = '1;

	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [PRIO_W-1:0]  prio;
		logic [TIME_W-1:0]  arrival;
		logic [TIME_W-1:0]  remaining;
		logic [TIME_W-1:0]  original;
	} slot_rec_t;

endpackage

@@ rtl/core/preemptive_priority_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_unit
// Table of process slots with a priority pick per tick; reports the pick
// and, on completion, completion, turnaround and waiting times.
// ----------------------------------------------------------------------------
// Usage: raise start with an action; the beat is taken at an edge where busy
// is low. A load or a clear takes effect at that edge and busy stays low, so
// the next beat may follow in the next cycle. A tick holds busy high while
// the single comparator walks the slot memory one entry per cycle through
// the registered read, the update state writes the chosen slot back and
// advances the clock, and the report state forms the times. The result
// beat then sits on the result ports for exactly one cycle with
// result_strobe high; the receiver cannot stall it, so sample it then. A new
// start is taken in that same cycle. Loads and clears give no result beat.
// Loads to a slot at or beyond SLOTS, loads with a zero burst and action
// code 3 are dropped silently.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_unit #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  slot,
	input  logic [15:0] proc_ident,
	input  logic [7:0]  prio_level,
	input  logic [15:0] arrival,
	input  logic [15:0] burst,
	output logic        result_strobe,
	output logic [15:0] chosen_ident,
	output logic [3:0]  chosen_slot,
	output logic        idle,
	output logic        finished,
	output logic [31:0] completion,
	output logic [31:0] turnaround,
	output logic [31:0] waiting,
	output logic        all_done
);
	import pps_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE,
		ST_REPORT
	} state_t;

	state_t state_q;

	// Per-slot flags live in flops so a clear empties the table at once.
	logic [SLOTS-1:0] valid_q;
	logic [SLOTS-1:0] fin_q;
	logic [CNT_W-1:0] loaded_cnt_q;
	logic [CNT_W-1:0] finished_cnt_q;
	logic [CLOCK_W-1:0] clock_q;

	// Scan pipeline: read issue counter, then compare stage on read data.
	logic [CNT_W-1:0] scan_cnt_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;

	// Running best candidate.
	logic             found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [PRIO_W-1:0] best_prio_q;
	slot_rec_t        best_rec_q;

	// Update to report handoff.
	logic               fin_now_q;
	logic [CLOCK_W-1:0] tat_q;

	logic        accept;
	logic        do_load;
	logic        do_tick;
	logic        do_clear;
	logic [IDX_W-1:0] load_idx;
	logic        scan_issue;
	logic        cand_win;
	logic [CLOCK_W-1:0] clock_next;
	logic [TIME_W-1:0]  rem_next;
	logic        fin_next;
	logic [CLOCK_W-1:0] arr_ext;
	logic [CLOCK_W-1:0] org_ext;

	logic        ram_we;
	logic [IDX_W-1:0] ram_waddr;
	slot_rec_t   ram_wdata;
	slot_rec_t   ram_rdata;
	slot_rec_t   load_rec;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign do_load  = accept && (action == ACT_LOAD) && (burst != '0) &&
		(32'(slot) < SLOTS);
	assign do_tick  = accept && (action == ACT_TICK);
	assign do_clear = accept && (action == ACT_CLEAR);
	assign load_idx = IDX_W'(slot);

	assign scan_issue = (state_q == ST_SCAN) && (scan_cnt_q != SCAN_END);

	// A slot wins when loaded, unfinished, arrived and strictly above the
	// best priority so far; strict compare keeps ties on the lowest slot.
	assign cand_win = cmp_vld_s1 && valid_q[cmp_idx_s1] && !fin_q[cmp_idx_s1] &&
		({{(CLOCK_W - TIME_W){1'b0}}, ram_rdata.arrival} <= clock_q) &&
		(ram_rdata.prio > best_prio_q);

	assign clock_next = (clock_q == CLOCK_MAX) ? clock_q : clock_q + CLOCK_W'(1);
	assign rem_next   = best_rec_q.remaining - TIME_W'(1);
	assign fin_next   = found_q && (rem_next == '0);
	assign arr_ext    = {{(CLOCK_W - TIME_W){1'b0}}, best_rec_q.arrival};
	assign org_ext    = {{(CLOCK_W - TIME_W){1'b0}}, best_rec_q.original};

	always_comb begin
		load_rec.ident     = proc_ident;
		load_rec.prio      = prio_level;
		load_rec.arrival   = arrival;
		load_rec.remaining = burst;
		load_rec.original  = burst;
	end

	// Load writes in idle, the chosen slot is written back in update; the
	// FSM keeps these apart from the scan reads, so no forwarding is needed.
	always_comb begin
		ram_we    = do_load;
		ram_waddr = load_idx;
		ram_wdata = load_rec;
		if (state_q == ST_UPDATE) begin
			ram_we              = found_q;
			ram_waddr           = best_idx_q;
			ram_wdata           = best_rec_q;
			ram_wdata.remaining = rem_next;
		end
	end

	pps_slot_ram #(
		.DEPTH  (SLOTS),
		.ADDR_W (IDX_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (scan_issue),
		.raddr (scan_cnt_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Slot flags and counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			fin_q          <= '0;
			loaded_cnt_q   <= '0;
			finished_cnt_q <= '0;
		end else if (do_clear) begin
			valid_q        <= '0;
			fin_q          <= '0;
			loaded_cnt_q   <= '0;
			finished_cnt_q <= '0;
		end else if (do_load) begin
			// Reloading a finished slot pulls it back out of the finished count.
			if (!valid_q[load_idx]) begin
				loaded_cnt_q <= loaded_cnt_q + CNT_W'(1);
			end else if (fin_q[load_idx]) begin
				finished_cnt_q <= finished_cnt_q - CNT_W'(1);
			end
			valid_q[load_idx] <= 1'b1;
			fin_q[load_idx]   <= 1'b0;
		end else if (state_q == ST_UPDATE && fin_next) begin
			fin_q[best_idx_q] <= 1'b1;
			finished_cnt_q    <= finished_cnt_q + CNT_W'(1);
		end
	end

	// Best candidate payload and update results; no reset needed.
	always_ff @(posedge clk) begin
		if (cand_win) begin
			best_idx_q <= cmp_idx_s1;
			best_rec_q <= ram_rdata;
		end
		if (state_q == ST_UPDATE) begin
			fin_now_q <= fin_next;
			tat_q     <= (clock_next >= arr_ext) ? clock_next - arr_ext : '0;
		end
	end

	// Sequencer, clock and result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			clock_q       <= '0;
			scan_cnt_q    <= '0;
			cmp_vld_s1    <= 1'b0;
			cmp_idx_s1    <= '0;
			found_q       <= 1'b0;
			best_prio_q   <= '0;
			result_strobe <= 1'b0;
			chosen_ident  <= '0;
			chosen_slot   <= '0;
			idle          <= 1'b0;
			finished      <= 1'b0;
			completion    <= '0;
			turnaround    <= '0;
			waiting       <= '0;
			all_done      <= 1'b0;
		end else begin
			result_strobe <= 1'b0;
			cmp_vld_s1    <= scan_issue;
			cmp_idx_s1    <= scan_cnt_q[IDX_W-1:0];
			case (state_q)
				ST_IDLE: begin
					if (do_clear) begin
						clock_q <= '0;
					end
					if (do_tick) begin
						scan_cnt_q  <= '0;
						found_q     <= 1'b0;
						best_prio_q <= '0;
						state_q     <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + CNT_W'(1);
					end
					if (cand_win) begin
						found_q     <= 1'b1;
						best_prio_q <= ram_rdata.prio;
					end
					// Leave once the last read has gone through the compare.
					if (scan_cnt_q == SCAN_END && cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					clock_q <= clock_next;
					state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					result_strobe <= 1'b1;
					idle          <= !found_q;
					chosen_ident  <= found_q ? best_rec_q.ident : '0;
					chosen_slot   <= found_q ? 4'(best_idx_q) : '0;
					finished      <= fin_now_q;
					completion    <= fin_now_q ? clock_q : '0;
					turnaround    <= fin_now_q ? tat_q : '0;
					waiting       <= (fin_now_q && tat_q >= org_ext) ? tat_q - org_ext : '0;
					all_done      <= (finished_cnt_q == loaded_cnt_q);
					state_q       <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/pps_slot_ram.sv @@
// ----------------------------------------------------------------------------
// pps_slot_ram
// Slot record memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pps_slot_ram #(
	parameter int DEPTH = 16,
	parameter int ADDR_W = 4
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  pps_pkg::slot_rec_t  wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output pps_pkg::slot_rec_t  rdata
);
	import pps_pkg::*;

	slot_rec_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the preemptive priority scheduler. Loads, ticks and
// clears go in through the start/busy port. Each accepted beat updates a
// shadow copy of the slot table, clock and counts. Each tick queues the
// report it must produce, and every strobed result is compared field by
// field with the oldest queued report.
// ----------------------------------------------------------------------------
module tb_top;

	import pps_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int MAX_REPORTED = 10;

	// One input beat as the sender sees it.
	typedef struct packed {
		logic [ACTION_W-1:0] act;
		logic [SLOT_W-1:0]   slot;
		logic [IDENT_W-1:0]  ident;
		logic [PRIO_W-1:0]   prio;
		logic [TIME_W-1:0]   arrival;
		logic [TIME_W-1:0]   burst;
	} sched_beat_t;

	// What one tick must report.
	typedef struct packed {
		logic [IDENT_W-1:0] ident;
		logic [SLOT_W-1:0]  slot;
		logic               idle;
		logic               finished;
		logic [CLOCK_W-1:0] completion;
		logic [CLOCK_W-1:0] turnaround;
		logic [CLOCK_W-1:0] waiting;
		logic               all_done;
	} tick_report_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [3:0]         slot;
	logic [15:0]        proc_ident;
	logic [7:0]         prio_level;
	logic [15:0]        arrival;
	logic [15:0]        burst;
	logic               result_strobe;
	logic [15:0]        chosen_ident;
	logic [3:0]         chosen_slot;
	logic               idle;
	logic               finished;
	logic [31:0]        completion;
	logic [31:0]        turnaround;
	logic [31:0]        waiting;
	logic               all_done;

	preemptive_priority_scheduler_unit #(
		.SLOTS(SLOTS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.slot         (slot),
		.proc_ident   (proc_ident),
		.prio_level   (prio_level),
		.arrival      (arrival),
		.burst        (burst),
		.result_strobe(result_strobe),
		.chosen_ident (chosen_ident),
		.chosen_slot  (chosen_slot),
		.idle         (idle),
		.finished     (finished),
		.completion   (completion),
		.turnaround   (turnaround),
		.waiting      (waiting),
		.all_done     (all_done)
	);

	// Shadow of the scheduler state, advanced once per accepted beat.
	logic               table_valid [SLOTS];
	logic [IDENT_W-1:0] table_ident [SLOTS];
	logic [PRIO_W-1:0]  table_prio [SLOTS];
	logic [TIME_W-1:0]  table_arrival [SLOTS];
	logic [TIME_W-1:0]  table_left [SLOTS];
	logic [TIME_W-1:0]  table_burst [SLOTS];
	logic [CLOCK_W-1:0] sched_clock;
	int                 loaded_slots;
	int                 finished_slots;

	tick_report_t       pending_reports [$];
	tick_report_t       due_report;

	int  mismatches;
	int  cycle_count;
	int  counted_items;
	bit  gaps_on;

	// Coverage tallies for the closing summary.
	int  n_ticks;
	int  n_idle_ticks;
	int  n_finishes;
	int  n_loads;
	int  n_clears;
	int  n_drains;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Give up on a hung handshake or a lost result.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports outstanding",
				cycle_count, pending_reports.size());
			$display("[preemptive_priority_scheduler_unit] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Shadow scheduler
	// ------------------------------------------------------------------
	function automatic void wipe_schedule();
		for (int i = 0; i < SLOTS; i++) begin
			table_valid[i]   = 1'b0;
			table_ident[i]   = '0;
			table_prio[i]    = '0;
			table_arrival[i] = '0;
			table_left[i]    = '0;
			table_burst[i]   = '0;
		end
		sched_clock    = '0;
		loaded_slots   = 0;
		finished_slots = 0;
	endfunction

	// Apply one accepted beat to the shadow; a tick queues its report.
	function automatic void schedule_beat(input sched_beat_t b);
		tick_report_t       r;
		int                 pick;
		logic [PRIO_W-1:0]  best;
		logic [CLOCK_W-1:0] tat;
		case (b.act)
		ACT_LOAD: begin
			// Zero burst drops the load; a reload of a finished slot
			// takes it back out of the finished count.
			if (b.burst != '0) begin
				n_loads++;
				if (!table_valid[b.slot])
					loaded_slots++;
				else if (table_left[b.slot] == '0 && finished_slots > 0)
					finished_slots--;
				table_valid[b.slot]   = 1'b1;
				table_ident[b.slot]   = b.ident;
				table_prio[b.slot]    = b.prio;
				table_arrival[b.slot] = b.arrival;
				table_left[b.slot]    = b.burst;
				table_burst[b.slot]   = b.burst;
			end
		end
		ACT_TICK: begin
			r    = '0;
			pick = -1;
			best = '0;
			// Strictly greater keeps ties on the lowest slot and never
			// picks a zero priority.
			for (int i = 0; i < SLOTS; i++) begin
				if (table_valid[i] && table_left[i] != '0 &&
						{16'd0, table_arrival[i]} <= sched_clock &&
						table_prio[i] > best) begin
					pick = i;
					best = table_prio[i];
				end
			end
			if (sched_clock != CLOCK_MAX)
				sched_clock++;
			n_ticks++;
			if (pick < 0) begin
				r.idle = 1'b1;
				n_idle_ticks++;
			end else begin
				table_left[pick]--;
				r.ident = table_ident[pick];
				r.slot  = pick[SLOT_W-1:0];
				if (table_left[pick] == '0) begin
					tat = (sched_clock >= {16'd0, table_arrival[pick]}) ?
						sched_clock - {16'd0, table_arrival[pick]} : '0;
					finished_slots++;
					n_finishes++;
					r.finished   = 1'b1;
					r.completion = sched_clock;
					r.turnaround = tat;
					r.waiting    = (tat >= {16'd0, table_burst[pick]}) ?
						tat - {16'd0, table_burst[pick]} : '0;
				end
			end
			r.all_done = (finished_slots == loaded_slots);
			pending_reports.push_back(r);
		end
		ACT_CLEAR: begin
			n_clears++;
			wipe_schedule();
		end
		default: ;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------
	function automatic void check_field(input string name,
			input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTED)
				$display("cycle %0d: %s expected %0h got %0h",
					cycle_count, name, want, got);
		end
	endfunction

	// Results cannot be held off, so take every strobe on the edge that
	// ends its cycle.
	always @(posedge clk) begin
		if (arst_n && result_strobe) begin
			if (pending_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTED)
					$display("cycle %0d: result beat with no tick pending",
						cycle_count);
			end else begin
				due_report = pending_reports.pop_front();
				check_field("chosen_ident", 32'(due_report.ident), 32'(chosen_ident));
				check_field("chosen_slot", 32'(due_report.slot), 32'(chosen_slot));
				check_field("idle", 32'(due_report.idle), 32'(idle));
				check_field("finished", 32'(due_report.finished), 32'(finished));
				check_field("completion", due_report.completion, completion);
				check_field("turnaround", due_report.turnaround, turnaround);
				check_field("waiting", due_report.waiting, waiting);
				check_field("all_done", 32'(due_report.all_done), 32'(all_done));
			end
		end
	end

	// ------------------------------------------------------------------
	// Beat construction and driving
	// ------------------------------------------------------------------
	function automatic sched_beat_t make_beat(input logic [ACTION_W-1:0] act);
		sched_beat_t b;
		b.act     = act;
		b.slot    = SLOT_W'($urandom_range(0, SLOTS - 1));
		b.ident   = IDENT_W'($urandom);
		b.prio    = PRIO_W'($urandom);
		b.arrival = TIME_W'($urandom);
		b.burst   = TIME_W'($urandom);
		return b;
	endfunction

	function automatic sched_beat_t make_load(input logic [SLOT_W-1:0] s,
			input logic [IDENT_W-1:0] id, input logic [PRIO_W-1:0] p,
			input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] bu);
		sched_beat_t b;
		b.act     = ACT_LOAD;
		b.slot    = s;
		b.ident   = id;
		b.prio    = p;
		b.arrival = arr;
		b.burst   = bu;
		return b;
	endfunction

	// A load shaped to run soon: arrival near the current clock, short
	// bursts and crowded priorities for ties, with a tail of extremes.
	function automatic sched_beat_t random_load();
		sched_beat_t b;
		int          roll;
		b = make_beat(ACT_LOAD);
		roll = $urandom_range(0, 99);
		if (roll < 40)
			b.prio = PRIO_W'($urandom_range(1, 4));
		else if (roll < 45)
			b.prio = '0;
		else if (roll < 50)
			b.prio = '1;
		if ($urandom_range(0, 99) < 75)
			b.arrival = (sched_clock + 12 > 32'hFFFF) ? 16'hFFFF :
				sched_clock[15:0] + 16'($urandom_range(0, 12)) -
				16'($urandom_range(0, sched_clock > 4 ? 4 : sched_clock));
		roll = $urandom_range(0, 99);
		if (roll < 5)
			b.burst = '0;
		else if (roll < 85)
			b.burst = TIME_W'($urandom_range(1, 6));
		return b;
	endfunction

	// Present one beat and hold it until the edge that takes it.
	task automatic send_beat(input sched_beat_t b);
		if (gaps_on && $urandom_range(0, 99) < 21) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		start      <= 1'b1;
		action     <= b.act;
		slot       <= b.slot;
		proc_ident <= b.ident;
		prio_level <= b.prio;
		arrival    <= b.arrival;
		burst      <= b.burst;
		do @(posedge clk); while (busy);
		schedule_beat(b);
		if (b.act != ACT_UNUSED && !(b.act == ACT_LOAD && b.burst == '0))
			counted_items++;
	endtask

	// Drop start and hold off until every queued report has come back.
	task automatic wait_for_drain();
		start <= 1'b0;
		n_drains++;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Ticks on an empty table, the unused action code and a zero burst.
	task automatic test_empty_table();
		send_beat(make_beat(ACT_TICK));
		send_beat(make_beat(ACT_UNUSED));
		send_beat(make_load(4'd0, 16'hFFFF, 8'hFF, 16'h0000, 16'h0000));
		send_beat(make_beat(ACT_TICK));
	endtask

	// Priority order, ties to the lowest slot, a zero priority that never
	// runs, a slot that never arrives and a late arrival that preempts.
	task automatic test_priority_order();
		send_beat(make_load(4'd15, 16'hFFFF, 8'hFF, 16'h0000, 16'h0002));
		send_beat(make_load(4'd3, 16'h1234, 8'hFF, 16'h0000, 16'h0001));
		send_beat(make_load(4'd7, 16'h0077, 8'h00, 16'h0000, 16'h0001));
		send_beat(make_load(4'd9, 16'h0000, 8'hC8, 16'hFFFF, 16'hFFFF));
		send_beat(make_load(4'd2, 16'h0202, 8'h64, 16'h0000, 16'h0003));
		send_beat(make_load(4'd1, 16'h0101, 8'h96, 16'h0005, 16'h0001));
		repeat (8) send_beat(make_beat(ACT_TICK));
	endtask

	// A slot run to its finish, a reload of a running slot, a full drain, then a
	// clear and an arrival one unit after the restarted clock.
	task automatic test_reload_and_clear();
		send_beat(make_load(4'd3, 16'h3333, 8'h01, 16'h0000, 16'h0001));
		send_beat(make_beat(ACT_TICK));
		send_beat(make_load(4'd5, 16'h5555, 8'h0A, 16'h0000, 16'h0003));
		send_beat(make_beat(ACT_TICK));
		send_beat(make_load(4'd5, 16'hAAAA, 8'h0A, 16'h0000, 16'h0001));
		send_beat(make_beat(ACT_TICK));
		wait_for_drain();
		send_beat(make_beat(ACT_CLEAR));
		send_beat(make_load(4'd0, 16'hA5A5, 8'h08, 16'h0001, 16'h0001));
		send_beat(make_beat(ACT_TICK));
		send_beat(make_beat(ACT_TICK));
	endtask

	// Mostly workloads: an optional clear, a handful of loads, then a run
	// of ticks with the odd late load to force preemption. The rest is
	// noise with every action code and raw field values. Idle gaps drop
	// out for a long middle stretch.
	task automatic test_random_scenarios();
		int goal;
		goal = counted_items + RANDOM_ITEMS;
		while (counted_items < goal) begin
			gaps_on = !(counted_items > goal - 800 && counted_items < goal - 450);
			if ($urandom_range(0, 99) < 80) begin
				if ($urandom_range(0, 1))
					send_beat(make_beat(ACT_CLEAR));
				repeat ($urandom_range(1, 6)) send_beat(random_load());
				repeat ($urandom_range(2, 30)) begin
					if ($urandom_range(0, 9) == 0)
						send_beat(random_load());
					send_beat(make_beat(ACT_TICK));
				end
			end else begin
				repeat ($urandom_range(1, 4))
					send_beat(make_beat(2'($urandom_range(0, 3))));
			end
			if ($urandom_range(0, 19) == 0)
				wait_for_drain();
		end
		gaps_on = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n     <= 1'b0;
		start      <= 1'b0;
		action     <= ACT_LOAD;
		slot       <= '0;
		proc_ident <= '0;
		prio_level <= '0;
		arrival    <= '0;
		burst      <= '0;
		gaps_on    = 1'b1;
		mismatches = 0;
		cycle_count = 0;
		counted_items = 0;
		n_ticks = 0;
		n_idle_ticks = 0;
		n_finishes = 0;
		n_loads = 0;
		n_clears = 0;
		n_drains = 0;
		wipe_schedule();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_priority_order();
		test_reload_and_clear();
		test_random_scenarios();

		// Let the last tick report, then idle past the pick latency.
		wait_for_drain();
		repeat (SLOTS + 8) @(posedge clk);

		$display("covered %0d ticks (%0d idle, %0d completions), %0d loads, %0d clears",
			n_ticks, n_idle_ticks, n_finishes, n_loads, n_clears);
		$display("sender held off for a full drain %0d times; %0d field mismatches",
			n_drains, mismatches);
		if (mismatches == 0 && pending_reports.size() == 0) begin
			$display("[preemptive_priority_scheduler_unit] OK");
		end else begin
			$display("[preemptive_priority_scheduler_unit] ERROR");
		end
		$finish;
	end

endmodule
